@@ hdl/biou_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biou_pkg
// Shared beat layout, result codes and flag types for the class-gated box
// intersection-over-union pipeline.
// ----------------------------------------------------------------------------
package biou_pkg;

  // Field widths of one input beat
  localparam int FIELD_W = 16;
  localparam int CLASS_W = 10;
  localparam int IMAGE_W = 8;

  // Input tdata layout, lowest bit first
  localparam int A_LEFT_LSB   = 0;
  localparam int A_TOP_LSB    = 16;
  localparam int A_RIGHT_LSB  = 32;
  localparam int A_BOTTOM_LSB = 48;
  localparam int A_CLASS_LSB  = 64;
  localparam int A_IMAGE_LSB  = 74;
  localparam int B_LEFT_LSB   = 82;
  localparam int B_TOP_LSB    = 98;
  localparam int B_RIGHT_LSB  = 114;
  localparam int B_BOTTOM_LSB = 130;
  localparam int B_CLASS_LSB  = 146;
  localparam int B_IMAGE_LSB  = 156;
  localparam int IN_DATA_W    = 168;

  // Result layout
  localparam int IOU_BITS   = 18;
  localparam int OUT_DATA_W = 24;
  localparam int QUOT_BITS  = 17;

  localparam logic signed [IOU_BITS-1:0] IOU_MAX  = 18'sh1FFFF;
  localparam logic signed [IOU_BITS-1:0] IOU_MIN  = 18'sh20000;
  localparam logic signed [IOU_BITS-1:0] IOU_ZERO = 18'sh00000;

  // Per-item flags carried down the divider stages
  typedef struct packed {
    logic match;  // class and image indices agree
    logic bad;    // union area not positive
    logic sat;    // ratio at or above the result range
  } biou_flags_t;

endpackage

@@ hdl/box_iou_class_gated.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_iou_class_gated
// Intersection over union of two inclusive-corner boxes, gated on class label
// and image index, as a fully pipelined stream block.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on in_tvalid/in_tready/in_tdata, each carrying one box
//   pair; results leave on out_tvalid/out_tready/out_tdata/out_tuser, one per
//   input beat, in order.
//   Throughput: one box pair per clock while out_tready does not stall the
//   output. Stages: 4 arithmetic stages, 17 restoring-divider stages, one
//   output register. The divider resolves one quotient bit per stage, so
//   its 17 result bits set the depth.
//   Backpressure: the whole pipeline advances only when the output register
//   is empty or being taken; in_tready is low while a result waits and
//   out_tready is low, so nothing is dropped or duplicated.
//   Reset (rst_n low, synchronous): all stage valid bits clear, the pipe is
//   empty and in_tready is high on the next cycle.
//   Results: iou is signed Q.FRAC_BITS, truncated, saturated at the 18-bit
//   maximum; a label or image mismatch wins and gives minus one (the 18-bit
//   minimum if FRAC_BITS >= 17); else a union not positive gives zero, tuser set.
// ----------------------------------------------------------------------------
module box_iou_class_gated #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Box pair beats
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // a_left, a_top, a_right, a_bottom, a_class, a_image,
  // b_left, b_top, b_right, b_bottom, b_class, b_image, zero pad
  input  logic [biou_pkg::IN_DATA_W-1:0]      in_tdata,
  // Result beats
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // iou, zero pad
  output logic [biou_pkg::OUT_DATA_W-1:0]     out_tdata,
  // bad_union
  output logic [0:0]                          out_tuser
);

  // Widths
  localparam int CW = (COORD_BITS < biou_pkg::FIELD_W) ? COORD_BITS : biou_pkg::FIELD_W;
  localparam int SW = CW + 2;            // signed extent
  localparam int PW = 2 * SW;            // signed box area
  localparam int IW = 2 * CW + 1;        // unsigned intersection area
  localparam int UW = PW + 1;            // signed union area
  localparam int DW = UW - 1;            // divisor, union known positive
  localparam int QB = biou_pkg::QUOT_BITS;
  localparam int NW = IW + FRAC_BITS;
  localparam int RW = (NW > DW + QB) ? NW : DW + QB;

  localparam logic signed [biou_pkg::IOU_BITS-1:0] IOU_MISS =
    (FRAC_BITS >= QB) ? biou_pkg::IOU_MIN : biou_pkg::IOU_BITS'(-(1 << FRAC_BITS));

  // Pipeline advance
  logic en;
  logic out_valid_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // ---- Stage 1: extents and clamped overlap ----
  logic [CW-1:0]        a_left, a_top, a_right, a_bottom;
  logic [CW-1:0]        b_left, b_top, b_right, b_bottom;
  logic signed [SW-1:0] al, at, ar, ab, bl, bt, br, bb;
  logic signed [SW-1:0] ox, oy;
  logic signed [SW-1:0] wa_nxt, ha_nxt, wb_nxt, hb_nxt;
  logic [CW:0]          ix_nxt, iy_nxt;
  logic                 match_nxt;

  assign a_left   = in_tdata[biou_pkg::A_LEFT_LSB   +: CW];
  assign a_top    = in_tdata[biou_pkg::A_TOP_LSB    +: CW];
  assign a_right  = in_tdata[biou_pkg::A_RIGHT_LSB  +: CW];
  assign a_bottom = in_tdata[biou_pkg::A_BOTTOM_LSB +: CW];
  assign b_left   = in_tdata[biou_pkg::B_LEFT_LSB   +: CW];
  assign b_top    = in_tdata[biou_pkg::B_TOP_LSB    +: CW];
  assign b_right  = in_tdata[biou_pkg::B_RIGHT_LSB  +: CW];
  assign b_bottom = in_tdata[biou_pkg::B_BOTTOM_LSB +: CW];

  always_comb begin
    al = $signed(SW'(a_left));
    at = $signed(SW'(a_top));
    ar = $signed(SW'(a_right));
    ab = $signed(SW'(a_bottom));
    bl = $signed(SW'(b_left));
    bt = $signed(SW'(b_top));
    br = $signed(SW'(b_right));
    bb = $signed(SW'(b_bottom));

    wa_nxt = ar - al + SW'(1);
    ha_nxt = ab - at + SW'(1);
    wb_nxt = br - bl + SW'(1);
    hb_nxt = bb - bt + SW'(1);

    ox = ((ar < br) ? ar : br) - ((al > bl) ? al : bl) + SW'(1);
    oy = ((ab < bb) ? ab : bb) - ((at > bt) ? at : bt) + SW'(1);
    ix_nxt = ox[SW-1] ? '0 : ox[CW:0];
    iy_nxt = oy[SW-1] ? '0 : oy[CW:0];

    match_nxt =
      (in_tdata[biou_pkg::A_CLASS_LSB +: biou_pkg::CLASS_W] ==
       in_tdata[biou_pkg::B_CLASS_LSB +: biou_pkg::CLASS_W]) &&
      (in_tdata[biou_pkg::A_IMAGE_LSB +: biou_pkg::IMAGE_W] ==
       in_tdata[biou_pkg::B_IMAGE_LSB +: biou_pkg::IMAGE_W]);
  end

  logic                 s1_valid_r;
  logic signed [SW-1:0] wa_r, ha_r, wb_r, hb_r;
  logic [CW:0]          ix_r, iy_r;
  logic                 s1_match_r;

  // ---- Stage 2: areas ----
  logic signed [PW-1:0] area_a_nxt, area_b_nxt;
  logic [IW-1:0]        inter_nxt;

  assign area_a_nxt = PW'(wa_r * ha_r);
  assign area_b_nxt = PW'(wb_r * hb_r);
  assign inter_nxt  = IW'(ix_r * iy_r);

  logic                 s2_valid_r;
  logic signed [PW-1:0] area_a_r, area_b_r;
  logic [IW-1:0]        s2_inter_r;
  logic                 s2_match_r;

  // ---- Stage 3: union ----
  logic signed [UW-1:0] uni_nxt;

  assign uni_nxt = UW'(area_a_r) + UW'(area_b_r) - UW'(s2_inter_r);

  logic                 s3_valid_r;
  logic signed [UW-1:0] uni_r;
  logic [IW-1:0]        s3_inter_r;
  logic                 s3_match_r;

  // ---- Divider: stage 0 loads numerator and range check, 1..QB one bit each ----
  logic [RW-1:0]         rem_nxt  [0:QB];
  logic [DW-1:0]         den_nxt  [0:QB];
  logic [QB-1:0]         quo_nxt  [0:QB];
  biou_pkg::biou_flags_t flg_nxt  [0:QB];

  logic [RW-1:0]         rem_r    [0:QB];
  logic [DW-1:0]         den_r    [0:QB];
  logic [QB-1:0]         quo_r    [0:QB];
  biou_pkg::biou_flags_t flg_r    [0:QB];
  logic [QB:0]           dv_valid_r;

  always_comb begin
    logic [RW-1:0] trial;
    logic          ge;
    // numerator and saturation test
    den_nxt[0]       = uni_r[DW-1:0];
    rem_nxt[0]       = RW'(s3_inter_r) << FRAC_BITS;
    quo_nxt[0]       = '0;
    flg_nxt[0].match = s3_match_r;
    flg_nxt[0].bad   = uni_r[UW-1] || (uni_r == '0);
    flg_nxt[0].sat   = rem_nxt[0] >= (RW'(uni_r[DW-1:0]) << QB);
    // restoring steps, most significant quotient bit first
    for (int k = 1; k <= QB; k++) begin
      trial      = RW'(den_r[k-1]) << (QB - k);
      ge         = rem_r[k-1] >= trial;
      rem_nxt[k] = ge ? (rem_r[k-1] - trial) : rem_r[k-1];
      den_nxt[k] = den_r[k-1];
      quo_nxt[k] = quo_r[k-1];
      quo_nxt[k][QB-k] = ge;
      flg_nxt[k] = flg_r[k-1];
    end
  end

  // ---- Output select ----
  logic signed [biou_pkg::IOU_BITS-1:0] iou_nxt, iou_r;
  logic                                 bad_nxt, bad_r;

  always_comb begin
    bad_nxt = 1'b0;
    if (!flg_r[QB].match) begin
      iou_nxt = IOU_MISS;
    end else if (flg_r[QB].bad) begin
      iou_nxt = biou_pkg::IOU_ZERO;
      bad_nxt = 1'b1;
    end else if (flg_r[QB].sat) begin
      iou_nxt = biou_pkg::IOU_MAX;
    end else begin
      iou_nxt = $signed({1'b0, quo_r[QB]});
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      dv_valid_r  <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= in_tvalid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      dv_valid_r  <= {dv_valid_r[QB-1:0], s3_valid_r};
      out_valid_r <= dv_valid_r[QB];
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      wa_r       <= wa_nxt;
      ha_r       <= ha_nxt;
      wb_r       <= wb_nxt;
      hb_r       <= hb_nxt;
      ix_r       <= ix_nxt;
      iy_r       <= iy_nxt;
      s1_match_r <= match_nxt;

      area_a_r   <= area_a_nxt;
      area_b_r   <= area_b_nxt;
      s2_inter_r <= inter_nxt;
      s2_match_r <= s1_match_r;

      uni_r      <= uni_nxt;
      s3_inter_r <= s2_inter_r;
      s3_match_r <= s2_match_r;

      for (int k = 0; k <= QB; k++) begin
        rem_r[k] <= rem_nxt[k];
        den_r[k] <= den_nxt[k];
        quo_r[k] <= quo_nxt[k];
        flg_r[k] <= flg_nxt[k];
      end

      iou_r <= iou_nxt;
      bad_r <= bad_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(biou_pkg::OUT_DATA_W - biou_pkg::IOU_BITS){1'b0}}, iou_r};
  assign out_tuser  = bad_r;

endmodule
